/* rtl/core/cqp_pkg.sv */
// ----------------------------------------------------------------------------
// Circular queue with peek: shared package
// Operation codes, result status codes and the controller command bundle.
// ----------------------------------------------------------------------------
package cqp_pkg;

   localparam int FUNC_WIDTH   = 3;
   localparam int PUSH_WIDTH   = 32;
   localparam int POS_WIDTH    = 5;
   localparam int READ_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int OCC_WIDTH    = 5;

   localparam logic [FUNC_WIDTH-1:0] FUNC_ENQUEUE = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_DEQUEUE = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_FRONT   = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_BACK    = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_INDEXED = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BADPOS = 2'd3;

   typedef struct packed {
      logic capture;
      logic execute;
      logic respond;
   } ctrl_cmd_type;

endpackage

/* rtl/core/cqp_ctrl.sv */
// ----------------------------------------------------------------------------
// Circular queue with peek: controller
// Sequences each transaction through capture, execute and respond steps.
// ----------------------------------------------------------------------------
module cqp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output cqp_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      busy        = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      cmd.respond = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/cqp_datapath.sv */
// ----------------------------------------------------------------------------
// Circular queue with peek: datapath
// Request registers, head and count pointers, slot memory and result registers.
// ----------------------------------------------------------------------------
module cqp_datapath #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cqp_pkg::ctrl_cmd_type               cmd,
   input  logic [cqp_pkg::FUNC_WIDTH-1:0]      req_func,
   input  logic [cqp_pkg::PUSH_WIDTH-1:0]      req_push_value,
   input  logic [cqp_pkg::POS_WIDTH-1:0]       req_position,
   output logic [cqp_pkg::READ_WIDTH-1:0]      rsp_read_value,
   output logic [cqp_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic [cqp_pkg::OCC_WIDTH-1:0]       rsp_occupancy
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int WW = (CW > cqp_pkg::POS_WIDTH) ? CW : cqp_pkg::POS_WIDTH;
   localparam logic [AW:0] DEPTH_A = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [cqp_pkg::FUNC_WIDTH-1:0]   func_ff;
   logic [DATA_WIDTH-1:0]            value_ff;
   logic [DATA_WIDTH-1:0]            value_in;
   logic [cqp_pkg::POS_WIDTH-1:0]    pos_ff;
   logic [AW-1:0]                    head_ff;
   logic [AW-1:0]                    head_in;
   logic [CW-1:0]                    held_ff;
   logic [CW-1:0]                    held_in;
   logic [cqp_pkg::STATUS_WIDTH-1:0] status_ff;
   logic [cqp_pkg::STATUS_WIDTH-1:0] status_in;
   logic                             rd_ok_ff;
   logic                             rd_ok_in;
   logic [DATA_WIDTH-1:0]            rd_data_ff;
   logic [DATA_WIDTH-1:0]            mem [DEPTH];

   logic [63:0]   push_ext;
   logic [63:0]   rd_ext;
   logic [WW-1:0] pos_w;
   logic [WW-1:0] held_w;
   logic [WW-1:0] offset;
   logic [AW:0]   sum;
   logic [AW:0]   wrapped;
   logic [AW-1:0] addr;
   logic          do_write;
   logic          do_pop;

   assign push_ext = 64'(req_push_value);
   assign value_in = push_ext[DATA_WIDTH-1:0];
   assign pos_w    = WW'(pos_ff);
   assign held_w   = WW'(held_ff);

   always_comb begin
      offset    = '0;
      held_in   = held_ff;
      status_in = cqp_pkg::STATUS_OK;
      rd_ok_in  = 1'b0;
      do_write  = 1'b0;
      do_pop    = 1'b0;
      case (func_ff)
         cqp_pkg::FUNC_ENQUEUE: begin
            offset = held_w;
            if (held_ff < DEPTH_C) begin
               do_write = 1'b1;
               held_in  = held_ff + CW'(1);
            end else begin
               status_in = cqp_pkg::STATUS_FULL;
            end
         end
         cqp_pkg::FUNC_DEQUEUE: begin
            offset = WW'(1);
            if (held_ff != '0) begin
               do_pop  = 1'b1;
               held_in = held_ff - CW'(1);
            end else begin
               status_in = cqp_pkg::STATUS_EMPTY;
            end
         end
         cqp_pkg::FUNC_FRONT: begin
            if (held_ff != '0) begin
               rd_ok_in = 1'b1;
            end else begin
               status_in = cqp_pkg::STATUS_EMPTY;
            end
         end
         cqp_pkg::FUNC_BACK: begin
            offset = held_w - WW'(1);
            if (held_ff != '0) begin
               rd_ok_in = 1'b1;
            end else begin
               status_in = cqp_pkg::STATUS_EMPTY;
            end
         end
         cqp_pkg::FUNC_INDEXED: begin
            offset = pos_w - WW'(1);
            if (pos_w == '0 || pos_w > held_w) begin
               status_in = cqp_pkg::STATUS_BADPOS;
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         default: begin
            status_in = cqp_pkg::STATUS_OK;
         end
      endcase
   end

   // The offset is below the depth whenever it is used, so one subtraction wraps it.
   assign sum     = {1'b0, head_ff} + {1'b0, offset[AW-1:0]};
   assign wrapped = (sum >= DEPTH_A) ? (sum - DEPTH_A) : sum;
   assign addr    = wrapped[AW-1:0];
   assign head_in = do_pop ? addr : head_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= value_in;
         pos_ff   <= req_position;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (do_write) begin
            mem[addr] <= value_ff;
         end
         rd_data_ff <= mem[addr];
         status_ff  <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         held_ff  <= '0;
         rd_ok_ff <= 1'b0;
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         held_ff  <= held_in;
         rd_ok_ff <= rd_ok_in;
      end
   end

   assign rd_ext         = 64'(rd_data_ff);
   assign rsp_read_value = rd_ok_ff ? rd_ext[cqp_pkg::READ_WIDTH-1:0] : '0;
   assign rsp_status     = status_ff;
   assign rsp_occupancy  = cqp_pkg::OCC_WIDTH'(held_ff);

endmodule

/* rtl/core/circular_queue_with_peek_core.sv */
// ----------------------------------------------------------------------------
// Circular queue with peek: top level
// Fixed-depth ring-buffer queue with enqueue, dequeue and peek operations.
// ----------------------------------------------------------------------------
// Usage. A transaction is offered on req_func, req_push_value and req_position
// with start high; it is taken at a rising edge where start is high and busy is
// low. Each transaction gives exactly one result, shown for a single cycle on
// rsp_read_value, rsp_status and rsp_occupancy with rsp_valid high, in the
// respond step that follows the execute step. The receiver cannot stall the
// result; it must take it. Busy is high only in the execute cycle, in which
// the slot memory is written or read through its single port, so a new
// transaction may be accepted in the same cycle as the previous result.
// Reset empties the queue and returns the controller to idle; the slot
// contents are not cleared, as only written entries are ever read.
// Enqueue on a full queue is dropped with status full, dequeue, front or back
// on an empty queue reports empty, and an indexed read outside one to the
// count reports a bad position.
// ----------------------------------------------------------------------------
module circular_queue_with_peek_core #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cqp_pkg::FUNC_WIDTH-1:0]      req_func,
   input  logic [cqp_pkg::PUSH_WIDTH-1:0]      req_push_value,
   input  logic [cqp_pkg::POS_WIDTH-1:0]       req_position,
   output logic                                rsp_valid,
   output logic [cqp_pkg::READ_WIDTH-1:0]      rsp_read_value,
   output logic [cqp_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic [cqp_pkg::OCC_WIDTH-1:0]       rsp_occupancy
);

   cqp_pkg::ctrl_cmd_type cmd;

   cqp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   cqp_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .req_position   (req_position),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

   assign rsp_valid = cmd.respond;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not enter execution");

   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("execution not followed by a result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_failed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != cqp_pkg::STATUS_OK) |-> rsp_read_value == '0)
      else $error("failed operation returned a non-zero value");

endmodule
